// ----- hdl/r2b_pkg.sv -----
// ---------------------------------------------------------------------------
// r2b_pkg: shared types and constants of the RGB565 to BMP24 streamer
// Geometry limits, register indexes, the command queue entry and the
// color expansion helpers.
// ---------------------------------------------------------------------------
package r2b_pkg;

  // geometry limits
  localparam int MaxWidth   = 512;
  localparam int MaxHeight  = 512;
  localparam int CfgW       = 10;
  localparam int DimW       = 10;
  localparam int CntW       = 9;
  localparam int IdxW       = 18;
  localparam int RowBytesW  = 11;
  localparam int SizeW      = 20;
  localparam int ByteIdxW   = 6;
  localparam int HdrLastIdx = 53;
  localparam int CmdDepth   = 2;
  localparam int CmdPtrW    = $clog2(CmdDepth);
  localparam int CmdCntW    = $clog2(CmdDepth + 1);

  // register reset values
  localparam logic [CfgW-1:0] WidthReset  = CfgW'(320);
  localparam logic [CfgW-1:0] HeightReset = CfgW'(240);
  localparam logic [CfgW-1:0] StrideReset = CfgW'(320);

  // register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FB_STRIDE    = 2'd2
  } cfg_reg_e;

  // request kinds
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_PIXEL = 1'b1
  } action_e;

  // effective image geometry
  typedef struct packed {
    logic [DimW-1:0]      width;
    logic [DimW-1:0]      height;
    logic [RowBytesW-1:0] row_bytes;
  } geom_t;

  // one queue entry: a header or one pixel with its padding
  typedef struct packed {
    logic                is_hdr;
    logic [7:0]          blue;
    logic [7:0]          green;
    logic [7:0]          red;
    logic [ByteIdxW-1:0] last_idx;
    logic                frame_end;
    logic [IdxW-1:0]     pix_idx;
  } cmd_t;

  // v*255/31 truncated, via reciprocal multiply (exact for 5-bit v)
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] s;
    logic [26:0] p;
    s = 13'(v) * 13'd255;
    p = 27'(s) * 27'd8457;
    return p[25:18];
  endfunction

  // v*255/63 truncated, via reciprocal multiply (exact for 6-bit v)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] s;
    logic [29:0] p;
    s = 14'(v) * 14'd255;
    p = 30'(s) * 30'd16645;
    return p[27:20];
  endfunction

endpackage

// ----- hdl/r2b_in_if.sv -----
// ---------------------------------------------------------------------------
// r2b_in_if: request channel of the streamer
// Valid/ready channel carrying the action code and one RGB565 pixel.
// ---------------------------------------------------------------------------
interface r2b_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] pixel;

  modport source (output valid, output action, output pixel, input ready);
  modport sink   (input valid, input action, input pixel, output ready);
endinterface

// ----- hdl/r2b_out_if.sv -----
// ---------------------------------------------------------------------------
// r2b_out_if: byte channel of the streamer
// Valid/ready channel carrying one BMP byte with its side information.
// ---------------------------------------------------------------------------
interface r2b_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                out_byte;
  logic                      last_of_run;
  logic [r2b_pkg::IdxW-1:0]  next_pixel_index;
  logic                      frame_done;

  modport source (output valid, output out_byte, output last_of_run,
                  output next_pixel_index, output frame_done, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input next_pixel_index, input frame_done, output ready);
endinterface

// ----- hdl/r2b_front.sv -----
// ---------------------------------------------------------------------------
// r2b_front: request intake and classification
// Holds the size registers and the column/row counters, expands pixel
// colors and builds one queue entry per request, including fetch index.
// ---------------------------------------------------------------------------
module r2b_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [r2b_pkg::CfgW-1:0]  cfg_wdata_i,
  r2b_in_if.sink                    in_chan,
  input  logic                      full_i,
  output logic                      push_o,
  output r2b_pkg::cmd_t             cmd_o,
  output r2b_pkg::geom_t            geom_o
);

  logic [r2b_pkg::CfgW-1:0] width_q, height_q, stride_q;
  logic [r2b_pkg::CntW-1:0] col_q, col_d, row_q, row_d;
  logic                     stage_v_q, stage_v_d;
  r2b_pkg::cmd_t            stage_q, stage_d;
  logic [r2b_pkg::DimW-1:0] w_eff, h_eff, w_m1, h_m1;
  logic [1:0]               pad;
  logic                     accept;
  logic                     row_end, frame_end;
  logic [r2b_pkg::CntW-1:0] row_clip, row_flip;
  logic [r2b_pkg::CntW+r2b_pkg::CfgW-1:0] prod;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= r2b_pkg::WidthReset;
      height_q <= r2b_pkg::HeightReset;
      stride_q <= r2b_pkg::StrideReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        r2b_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        r2b_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        r2b_pkg::CFG_FB_STRIDE:    stride_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective sizes: zero reads as one, large values saturate
  always_comb begin
    if (width_q == '0) begin
      w_eff = r2b_pkg::DimW'(1);
    end else if (width_q > r2b_pkg::DimW'(r2b_pkg::MaxWidth)) begin
      w_eff = r2b_pkg::DimW'(r2b_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = r2b_pkg::DimW'(1);
    end else if (height_q > r2b_pkg::DimW'(r2b_pkg::MaxHeight)) begin
      h_eff = r2b_pkg::DimW'(r2b_pkg::MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  // row padding: (4 - 3w mod 4) mod 4 equals w mod 4
  assign pad  = w_eff[1:0];
  assign w_m1 = w_eff - r2b_pkg::DimW'(1);
  assign h_m1 = h_eff - r2b_pkg::DimW'(1);

  assign geom_o.width     = w_eff;
  assign geom_o.height    = h_eff;
  assign geom_o.row_bytes = r2b_pkg::RowBytesW'({w_eff, 1'b0})
                          + r2b_pkg::RowBytesW'(w_eff)
                          + r2b_pkg::RowBytesW'(pad);

  // intake handshake: the stage frees when its entry enters the queue
  assign push_o        = stage_v_q && !full_i;
  assign in_chan.ready = !stage_v_q || !full_i;
  assign accept        = in_chan.valid && in_chan.ready;

  assign row_end   = {1'b0, col_q} >= w_m1;
  assign frame_end = {1'b0, row_q} >= h_m1;

  // counter update and entry classification
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    stage_d   = stage_q;
    stage_v_d = stage_v_q;
    if (push_o) begin
      stage_v_d = 1'b0;
    end
    if (accept) begin
      stage_v_d         = 1'b1;
      stage_d.blue      = r2b_pkg::expand5(in_chan.pixel[4:0]);
      stage_d.green     = r2b_pkg::expand6(in_chan.pixel[10:5]);
      stage_d.red       = r2b_pkg::expand5(in_chan.pixel[15:11]);
      stage_d.pix_idx   = '0;
      if (in_chan.action == r2b_pkg::ACT_START) begin
        stage_d.is_hdr    = 1'b1;
        stage_d.last_idx  = r2b_pkg::ByteIdxW'(r2b_pkg::HdrLastIdx);
        stage_d.frame_end = 1'b0;
        col_d             = '0;
        row_d             = '0;
      end else begin
        stage_d.is_hdr = 1'b0;
        if (row_end) begin
          stage_d.last_idx  = r2b_pkg::ByteIdxW'(2) + r2b_pkg::ByteIdxW'(pad);
          stage_d.frame_end = frame_end;
          col_d             = '0;
          row_d             = frame_end ? '0 : row_q + r2b_pkg::CntW'(1);
        end else begin
          stage_d.last_idx  = r2b_pkg::ByteIdxW'(2);
          stage_d.frame_end = 1'b0;
          col_d             = col_q + r2b_pkg::CntW'(1);
        end
      end
    end
  end

  // fetch index from the counters left by the staged request
  assign row_clip = ({1'b0, row_q} < h_eff) ? row_q : h_m1[r2b_pkg::CntW-1:0];
  assign row_flip = h_m1[r2b_pkg::CntW-1:0] - row_clip;
  assign prod     = row_flip * stride_q;

  always_comb begin
    cmd_o         = stage_q;
    cmd_o.pix_idx = prod[r2b_pkg::IdxW-1:0] + r2b_pkg::IdxW'(col_q);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      stage_v_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      stage_v_q <= stage_v_d;
    end
  end

  // staged entry payload
  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

endmodule

// ----- hdl/r2b_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// r2b_cmd_fifo: command queue between front and back
// Small register queue of entries; head is visible while not empty.
// ---------------------------------------------------------------------------
module r2b_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  r2b_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output r2b_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  r2b_pkg::cmd_t               mem_q [r2b_pkg::CmdDepth];
  logic [r2b_pkg::CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [r2b_pkg::CmdCntW-1:0] cnt_q;

  assign full_o  = cnt_q == r2b_pkg::CmdCntW'(r2b_pkg::CmdDepth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == r2b_pkg::CmdPtrW'(r2b_pkg::CmdDepth - 1)) ?
                    '0 : wr_ptr_q + r2b_pkg::CmdPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == r2b_pkg::CmdPtrW'(r2b_pkg::CmdDepth - 1)) ?
                    '0 : rd_ptr_q + r2b_pkg::CmdPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + r2b_pkg::CmdCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - r2b_pkg::CmdCntW'(1);
      end
    end
  end

endmodule

// ----- hdl/r2b_back.sv -----
// ---------------------------------------------------------------------------
// r2b_back: byte serializer
// Walks the head queue entry one byte per cycle while the sink is ready:
// 54 header bytes, or blue, green, red and padding, into an output register.
// ---------------------------------------------------------------------------
module r2b_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  r2b_pkg::geom_t geom_i,
  input  r2b_pkg::cmd_t  head_i,
  input  logic           empty_i,
  output logic           pop_o,
  r2b_out_if.source      out_chan
);

  localparam logic [7:0] ChB        = 8'h42;
  localparam logic [7:0] ChM        = 8'h4D;
  localparam logic [7:0] DataOffset = 8'd54;
  localparam logic [7:0] InfoSize   = 8'd40;
  localparam logic [7:0] Planes     = 8'd1;
  localparam logic [7:0] BitCount   = 8'd24;

  logic [r2b_pkg::SizeW-1:0]    data_q, fsize_q;
  logic [r2b_pkg::RowBytesW+r2b_pkg::DimW-1:0] data_prod;
  logic [r2b_pkg::ByteIdxW-1:0] cnt_q, cnt_d;
  logic                         out_v_q, out_v_d;
  logic [7:0]                   byte_q, byte_d;
  logic                         last_q, done_q, is_last;
  logic [r2b_pkg::IdxW-1:0]     idx_q;
  logic                         adv;

  // header byte decoder
  function automatic logic [7:0] hdr_byte(
    input logic [r2b_pkg::ByteIdxW-1:0] k,
    input logic [r2b_pkg::SizeW-1:0]    fsize,
    input logic [r2b_pkg::SizeW-1:0]    dsize,
    input logic [r2b_pkg::DimW-1:0]     w,
    input logic [r2b_pkg::DimW-1:0]     h
  );
    logic [7:0] b;
    unique case (k)
      6'd0:    b = ChB;
      6'd1:    b = ChM;
      6'd2:    b = fsize[7:0];
      6'd3:    b = fsize[15:8];
      6'd4:    b = 8'(fsize[r2b_pkg::SizeW-1:16]);
      6'd10:   b = DataOffset;
      6'd14:   b = InfoSize;
      6'd18:   b = w[7:0];
      6'd19:   b = 8'(w[r2b_pkg::DimW-1:8]);
      6'd22:   b = h[7:0];
      6'd23:   b = 8'(h[r2b_pkg::DimW-1:8]);
      6'd26:   b = Planes;
      6'd28:   b = BitCount;
      6'd34:   b = dsize[7:0];
      6'd35:   b = dsize[15:8];
      6'd36:   b = 8'(dsize[r2b_pkg::SizeW-1:16]);
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // pixel data and file sizes, tracked from the size registers
  assign data_prod = geom_i.row_bytes * geom_i.height;

  always_ff @(posedge clk_i) begin
    data_q  <= data_prod[r2b_pkg::SizeW-1:0];
    fsize_q <= data_prod[r2b_pkg::SizeW-1:0] + r2b_pkg::SizeW'(54);
  end

  // advance when an entry waits and the output stage is free
  assign adv     = !empty_i && (!out_v_q || out_chan.ready);
  assign is_last = cnt_q == head_i.last_idx;
  assign pop_o   = adv && is_last;

  // byte select
  always_comb begin
    if (head_i.is_hdr) begin
      byte_d = hdr_byte(cnt_q, fsize_q, data_q, geom_i.width, geom_i.height);
    end else begin
      case (cnt_q)
        6'd0:    byte_d = head_i.blue;
        6'd1:    byte_d = head_i.green;
        6'd2:    byte_d = head_i.red;
        default: byte_d = 8'h00;
      endcase
    end
  end

  // byte counter and output valid
  always_comb begin
    cnt_d   = cnt_q;
    out_v_d = out_v_q;
    if (out_chan.ready) begin
      out_v_d = 1'b0;
    end
    if (adv) begin
      out_v_d = 1'b1;
      cnt_d   = is_last ? '0 : cnt_q + r2b_pkg::ByteIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= byte_d;
      last_q <= is_last;
      done_q <= is_last && head_i.frame_end;
      idx_q  <= head_i.pix_idx;
    end
  end

  assign out_chan.valid            = out_v_q;
  assign out_chan.out_byte         = byte_q;
  assign out_chan.last_of_run      = last_q;
  assign out_chan.next_pixel_index = idx_q;
  assign out_chan.frame_done       = done_q;

endmodule

// ----- hdl/rgb565_to_bmp24_streamer.sv -----
// ---------------------------------------------------------------------------
// rgb565_to_bmp24_streamer: RGB565 framebuffer to 24-bit BMP byte stream
// Front stage classifies requests and tracks the pixel position, a
// two-entry command queue decouples it from the byte serializer.
// ---------------------------------------------------------------------------
// first byte path: front stage register, command queue, output register
// throughput: one byte per cycle while the sink is ready (byte-wide output
//   register); a pixel is 3 bytes (3 + pad at row end), a start request 54
// requests are taken back to back while the command queue has room
// reset: counters cleared, sizes 320 x 240 with stride 320; no clearing pass
module rgb565_to_bmp24_streamer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [r2b_pkg::CfgW-1:0]  cfg_wdata_i,
  r2b_in_if.sink                    in_chan,
  r2b_out_if.source                 out_chan
);

  r2b_pkg::cmd_t  push_cmd, head_cmd;
  r2b_pkg::geom_t geom;
  logic           cmd_push, cmd_pop, cmd_full, cmd_empty;

  // request intake
  r2b_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_chan     (in_chan),
    .full_i      (cmd_full),
    .push_o      (cmd_push),
    .cmd_o       (push_cmd),
    .geom_o      (geom)
  );

  // command queue
  r2b_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (push_cmd),
    .pop_i   (cmd_pop),
    .rdata_o (head_cmd),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  // byte serializer
  r2b_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .geom_i   (geom),
    .head_i   (head_cmd),
    .empty_i  (cmd_empty),
    .pop_o    (cmd_pop),
    .out_chan (out_chan)
  );

  // queue never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command queue overflow");

  // intake only stalls on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_chan.ready |-> cmd_full)
    else $error("intake stalled with queue room");

  // end of file only on the final byte of a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid && out_chan.frame_done |-> out_chan.last_of_run)
    else $error("frame end without last byte");

endmodule

// ----- tb/rgb565_to_bmp24_streamer_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb565_to_bmp24_streamer_test: self-checking bench for the BMP streamer
// Feeds start and pixel requests under random source gaps and sink stalls,
// predicts every header, pixel and pad byte with its fetch index and
// end-of-file flag, and compares the byte stream in order.
// ---------------------------------------------------------------------------
module rgb565_to_bmp24_streamer_test;

  localparam int HdrBytes     = 54;
  localparam int InfoSize     = 40;
  localparam int BitsPerPixel = 24;
  localparam int RandItems    = 140;
  localparam int HoldCycles   = 300;
  localparam int DrainCycles  = 60;
  localparam int StuckLimit   = 3000;
  localparam int BurstPixels  = 8;

  typedef struct packed {
    r2b_pkg::action_e action;
    logic [15:0]      pixel;
  } pix_req_t;

  typedef struct packed {
    logic [7:0]               data;
    logic                     last;
    logic [r2b_pkg::IdxW-1:0] idx;
    logic                     done;
  } bmp_byte_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we;
  r2b_pkg::cfg_reg_e        cfg_idx;
  logic [r2b_pkg::CfgW-1:0] cfg_wdata;

  r2b_in_if  req_if ();
  r2b_out_if byte_if ();

  rgb565_to_bmp24_streamer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_chan     (req_if),
    .out_chan    (byte_if)
  );

  // shadow registers and pixel position
  logic [r2b_pkg::CfgW-1:0] img_w, img_h, img_stride;
  int unsigned              col_pos, row_pos;

  pix_req_t  pix_requests[$];
  bmp_byte_t bytes_due[$];
  pix_req_t  cur_req;
  bit        req_held;
  int        src_wait, snk_wait, hold_left;
  bit        src_gaps_on, snk_stalls_on, sink_hold_req;
  int        fail_count;
  int        stuck_cycles;
  int        items_queued;

  always #10 clk_i = ~clk_i;

  // fetch index of the next pixel, row flipped
  function automatic logic [r2b_pkg::IdxW-1:0] fetch_index(int unsigned h);
    int unsigned row;
    row = (row_pos < h) ? row_pos : h - 1;
    return r2b_pkg::IdxW'(((h - 1 - row) * img_stride + col_pos) & 32'h3FFFF);
  endfunction

  // bytes caused by one accepted request
  function automatic void predict_bytes(pix_req_t rq);
    int unsigned w, h, row_bytes, pad, data_sz;
    logic [7:0]  seq[HdrBytes];
    int          n;
    bit          frame_end;
    logic [r2b_pkg::IdxW-1:0] idx;
    bmp_byte_t   e;
    w = (img_w == 0) ? 1 : ((img_w > r2b_pkg::MaxWidth) ? r2b_pkg::MaxWidth : img_w);
    h = (img_h == 0) ? 1 : ((img_h > r2b_pkg::MaxHeight) ? r2b_pkg::MaxHeight : img_h);
    row_bytes = (3 * w + 3) & ~32'd3;
    pad = row_bytes - 3 * w;
    frame_end = 1'b0;
    n = 0;
    if (rq.action == r2b_pkg::ACT_START) begin
      data_sz = row_bytes * h;
      for (int i = 0; i < HdrBytes; i++) seq[i] = 8'h00;
      seq[0] = 8'h42;
      seq[1] = 8'h4D;
      for (int i = 0; i < 4; i++) begin
        seq[2 + i]  = 8'((HdrBytes + data_sz) >> (8 * i));
        seq[10 + i] = 8'(HdrBytes >> (8 * i));
        seq[14 + i] = 8'(InfoSize >> (8 * i));
        seq[18 + i] = 8'(w >> (8 * i));
        seq[22 + i] = 8'(h >> (8 * i));
        seq[34 + i] = 8'(data_sz >> (8 * i));
      end
      seq[26] = 8'd1;
      seq[28] = 8'(BitsPerPixel);
      col_pos = 0;
      row_pos = 0;
      n = HdrBytes;
    end else begin
      seq[0] = 8'((32'(rq.pixel[4:0]) * 255) / 31);
      seq[1] = 8'((32'(rq.pixel[10:5]) * 255) / 63);
      seq[2] = 8'((32'(rq.pixel[15:11]) * 255) / 31);
      n = 3;
      if (col_pos >= w - 1) begin
        for (int i = 0; i < int'(pad); i++) seq[n++] = 8'h00;
        col_pos = 0;
        if (row_pos >= h - 1) begin
          row_pos = 0;
          frame_end = 1'b1;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    end
    idx = fetch_index(h);
    for (int i = 0; i < n; i++) begin
      e.data = seq[i];
      e.last = (i == n - 1);
      e.idx  = idx;
      e.done = (i == n - 1) && frame_end;
      bytes_due.push_back(e);
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_held = 1'b0;
      src_wait = 0;
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_bytes(cur_req);
        req_held = 1'b0;
        src_wait = src_gaps_on ? $urandom_range(0, 19) : 0;
      end
      if (!req_held) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (pix_requests.size() > 0) begin
          cur_req = pix_requests.pop_front();
          req_held = 1'b1;
        end
      end
      req_if.valid  <= req_held;
      req_if.action <= cur_req.action;
      req_if.pixel  <= cur_req.pixel;
    end
  end

  // byte monitor and sink stalls
  always @(posedge clk_i) begin
    bmp_byte_t e;
    if (!rst_ni) begin
      snk_wait = 0;
      hold_left = 0;
      byte_if.ready <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected byte %0h", $time, byte_if.out_byte);
          fail_count++;
        end else begin
          e = bytes_due.pop_front();
          if (byte_if.out_byte !== e.data) begin
            $display("%0t: out_byte expected %0h got %0h", $time, e.data, byte_if.out_byte);
            fail_count++;
          end
          if (byte_if.last_of_run !== e.last) begin
            $display("%0t: last_of_run expected %0b got %0b", $time, e.last,
                     byte_if.last_of_run);
            fail_count++;
          end
          if (byte_if.next_pixel_index !== e.idx) begin
            $display("%0t: next_pixel_index expected %0d got %0d", $time, e.idx,
                     byte_if.next_pixel_index);
            fail_count++;
          end
          if (byte_if.frame_done !== e.done) begin
            $display("%0t: frame_done expected %0b got %0b", $time, e.done,
                     byte_if.frame_done);
            fail_count++;
          end
        end
        snk_wait = snk_stalls_on ? $urandom_range(0, 19) : 0;
      end
      if (sink_hold_req) begin
        hold_left = HoldCycles;
        sink_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_if.ready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        byte_if.ready <= 1'b0;
      end else begin
        byte_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request and no byte taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (byte_if.valid && byte_if.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no progress for %0d cycles", $time, stuck_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(r2b_pkg::cfg_reg_e idx, logic [r2b_pkg::CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      r2b_pkg::CFG_IMAGE_WIDTH:  img_w = val;
      r2b_pkg::CFG_IMAGE_HEIGHT: img_h = val;
      default:                   img_stride = val;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(logic [r2b_pkg::CfgW-1:0] w, logic [r2b_pkg::CfgW-1:0] h,
                              logic [r2b_pkg::CfgW-1:0] s);
    write_reg(r2b_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(r2b_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(r2b_pkg::CFG_FB_STRIDE, s);
  endtask

  task automatic add_request(r2b_pkg::action_e act, logic [15:0] px);
    pix_req_t rq;
    rq.action = act;
    rq.pixel  = px;
    pix_requests.push_back(rq);
    items_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pix_requests.size() != 0 || req_held || bytes_due.size() != 0);
  endtask

  // stimulus and end of run
  initial begin
    int unsigned w, h, n_pix;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = r2b_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.action = r2b_pkg::ACT_START;
    req_if.pixel = '0;
    byte_if.ready = 1'b0;
    cur_req = '0;
    img_w = r2b_pkg::WidthReset;
    img_h = r2b_pkg::HeightReset;
    img_stride = r2b_pkg::StrideReset;
    col_pos = 0;
    row_pos = 0;
    fail_count = 0;
    stuck_cycles = 0;
    items_queued = 0;
    src_gaps_on = 1'b1;
    snk_stalls_on = 1'b1;
    sink_hold_req = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: a pixel before any start, then color extremes
    add_request(r2b_pkg::ACT_PIXEL, 16'h1234);
    add_request(r2b_pkg::ACT_START, 16'h0000);
    add_request(r2b_pkg::ACT_PIXEL, 16'h0000);
    add_request(r2b_pkg::ACT_PIXEL, 16'hFFFF);
    add_request(r2b_pkg::ACT_PIXEL, 16'hF800);
    add_request(r2b_pkg::ACT_PIXEL, 16'h07E0);
    add_request(r2b_pkg::ACT_PIXEL, 16'h001F);
    wait_idle();

    // one pixel image: one pad byte, every pixel ends the file
    set_geometry(10'd1, 10'd1, 10'd1);
    add_request(r2b_pkg::ACT_START, 16'hFFFF);
    add_request(r2b_pkg::ACT_PIXEL, 16'hFFFF);
    add_request(r2b_pkg::ACT_PIXEL, 16'h8410);
    wait_idle();

    // zero sizes taken as one, zero stride
    set_geometry(10'd0, 10'd0, 10'd0);
    add_request(r2b_pkg::ACT_START, 16'h0000);
    add_request(r2b_pkg::ACT_PIXEL, 16'h7BEF);
    wait_idle();

    // oversize saturates, fetch index wraps
    set_geometry(10'h3FF, 10'h3FF, 10'h3FF);
    add_request(r2b_pkg::ACT_START, 16'h0000);
    add_request(r2b_pkg::ACT_PIXEL, 16'hA5A5);
    wait_idle();

    // shrink under a frame in progress: next pixel ends row and file
    set_geometry(10'd5, 10'd4, 10'd7);
    add_request(r2b_pkg::ACT_START, 16'h0000);
    for (int i = 0; i < 7; i++) begin
      add_request(r2b_pkg::ACT_PIXEL, 16'($urandom_range(0, 65535)));
    end
    wait_idle();
    set_geometry(10'd2, 10'd2, 10'd7);
    add_request(r2b_pkg::ACT_PIXEL, 16'h5555);
    wait_idle();

    // random frames under varying geometry
    items_queued = 0;
    while (items_queued < RandItems) begin
      case ($urandom_range(0, 5))
        0:       set_geometry(10'($urandom_range(1, 4)), 10'd1, 10'($urandom_range(0, 1023)));
        1:       set_geometry(10'd512, 10'd2, 10'($urandom_range(0, 1023)));
        default: set_geometry(10'($urandom_range(1, 8)), 10'($urandom_range(1, 3)),
                              10'($urandom_range(1, 16)));
      endcase
      src_gaps_on   = $urandom_range(0, 3) != 0;
      snk_stalls_on = $urandom_range(0, 3) != 0;
      if (items_queued == 0) begin
        // long sink hold with a pixel burst so the intake stalls
        src_gaps_on = 1'b0;
        sink_hold_req = 1'b1;
        for (int i = 0; i < BurstPixels; i++) begin
          add_request(r2b_pkg::ACT_PIXEL, 16'($urandom_range(0, 65535)));
        end
      end
      w = (img_w > r2b_pkg::MaxWidth) ? r2b_pkg::MaxWidth : img_w;
      h = img_h;
      for (int f = $urandom_range(1, 2); f > 0; f--) begin
        n_pix = (w > 8) ? $urandom_range(1, 6) : w * h;
        if ($urandom_range(0, 7) != 0) begin
          add_request(r2b_pkg::ACT_START, 16'($urandom_range(0, 65535)));
        end
        if ($urandom_range(0, 5) == 0) n_pix = $urandom_range(0, n_pix + 2);
        for (int i = 0; i < int'(n_pix); i++) begin
          if ($urandom_range(0, 19) == 0) begin
            add_request(r2b_pkg::ACT_START, 16'($urandom_range(0, 65535)));
          end else begin
            add_request(r2b_pkg::ACT_PIXEL, 16'($urandom_range(0, 65535)));
          end
        end
      end
      wait_idle();
    end

    // drain and report
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/r2b_pkg.sv
hdl/r2b_in_if.sv
hdl/r2b_out_if.sv
hdl/r2b_front.sv
hdl/r2b_cmd_fifo.sv
hdl/r2b_back.sv
hdl/rgb565_to_bmp24_streamer.sv
tb/rgb565_to_bmp24_streamer_test.sv
